### rtl/core/plob_pkg.sv
`default_nettype none
package plob_pkg;

  localparam int unsigned PRICE_W = 14;
  localparam int unsigned SIZE_W  = 47;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ENTRY_W = PRICE_W + SIZE_W;
  localparam logic [PRICE_W-1:0] PRICE_MAX = 14'd9999;

  typedef enum logic [1:0] {
    KIND_INCR  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_SNAP  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_APPLY,
    OP_CLEAR,
    OP_INVALID
  } op_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SRCH_RD,
    BK_SRCH_CMP,
    BK_DECIDE,
    BK_SHL_RD,
    BK_SHL_WR,
    BK_SHR_RD,
    BK_SHR_WR,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    op_e               op;
    logic              is_bid;
    logic              keep_zero;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  size;
    logic [TIME_W-1:0]  upd_time;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [PRICE_W-1:0] best_bid_price;
    logic [SIZE_W-1:0]  best_bid_size;
    logic [PRICE_W-1:0] best_ask_price;
    logic [SIZE_W-1:0]  best_ask_size;
    logic [6:0]         bid_levels;
    logic [6:0]         ask_levels;
    logic [TIME_W-1:0]  book_time;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/plob_ram.sv
`default_nettype none
module plob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/plob_front.sv
`default_nettype none
module plob_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [2:0]    s_user_i,
  input  wire logic [127:0]  s_data_i,
  output logic               cmd_valid_o,
  output plob_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);
  import plob_pkg::*;

  kind_e             kind;
  logic [47:0]       size_raw;
  logic [PRICE_W-1:0] price;
  cmd_t              cls;
  cmd_t              slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;
  logic              push, pop;

  // classify: validity of price and size sign
  always_comb begin
    kind     = kind_e'(s_user_i[1:0]);
    price    = s_data_i[13:0];
    size_raw = s_data_i[61:14];
    cls.is_bid    = s_user_i[2];
    cls.keep_zero = (kind == KIND_SNAP);
    cls.price     = price;
    cls.size      = size_raw[SIZE_W-1:0];
    cls.upd_time  = s_data_i[125:62];
    unique case (kind)
      KIND_CLEAR: cls.op = OP_CLEAR;
      KIND_INCR, KIND_SNAP: begin
        if (price != '0 && price <= PRICE_MAX && !size_raw[47]) begin
          cls.op = OP_APPLY;
        end else begin
          cls.op = OP_INVALID;
        end
      end
      default: cls.op = OP_INVALID;
    endcase
  end

  assign s_ready_o   = (fill_q != 2'd2);
  assign push        = s_valid_i && s_ready_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end
endmodule
`default_nettype wire

### rtl/core/plob_back.sv
`default_nettype none
module plob_back #(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cmd_valid_i,
  input  plob_pkg::cmd_t                        cmd_i,
  output logic                                  cmd_pop_o,
  input  wire logic                             res_ready_i,
  output logic                                  res_valid_o,
  output plob_pkg::res_t                        res_o,
  output logic [$clog2(BOOK_DEPTH+1)-1:0]       bid_cnt_o,
  output logic [$clog2(BOOK_DEPTH+1)-1:0]       ask_cnt_o
);
  import plob_pkg::*;

  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

  bk_state_e          state_q, state_d;
  cmd_t               cur_q;
  logic [CW-1:0]      n_q, i_q, pos_q;
  logic               same_q;
  logic [CW-1:0]      bid_cnt_q, ask_cnt_q;
  logic [TIME_W-1:0]  time_q;
  logic [ENTRY_W-1:0] best_bid_q, best_ask_q;
  status_e            status_q;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rd_bid, rd_ask, rdata;
  logic [PRICE_W-1:0] rd_price;
  logic               better, remove;

  plob_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk_i, .we_i(we && cur_q.is_bid), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd_bid)
  );
  plob_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_ask_ram (
    .clk_i, .we_i(we && !cur_q.is_bid), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd_ask)
  );

  assign rdata    = cur_q.is_bid ? rd_bid : rd_ask;
  assign rd_price = rdata[ENTRY_W-1:SIZE_W];
  assign better   = cur_q.is_bid ? (rd_price > cur_q.price) : (rd_price < cur_q.price);
  assign remove   = (cur_q.size == '0) && !cur_q.keep_zero;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_APPLY) ? BK_SRCH_RD : BK_DONE;
        end
      end
      BK_SRCH_RD:  state_d = (i_q >= n_q) ? BK_DECIDE : BK_SRCH_CMP;
      BK_SRCH_CMP: state_d = better ? BK_SRCH_RD : BK_DECIDE;
      BK_DECIDE: begin
        if (remove) begin
          state_d = same_q ? BK_SHL_RD : BK_DONE;
        end else if (same_q || (n_q >= DEPTH_C && i_q >= DEPTH_C)) begin
          state_d = BK_DONE;
        end else begin
          state_d = BK_SHR_RD;
        end
      end
      BK_SHL_RD: state_d = (i_q + CW'(1) < n_q) ? BK_SHL_WR : BK_DONE;
      BK_SHL_WR: state_d = BK_SHL_RD;
      BK_SHR_RD: state_d = (i_q > pos_q) ? BK_SHR_WR : BK_DONE;
      BK_SHR_WR: state_d = BK_SHR_RD;
      BK_DONE:   state_d = res_ready_i ? BK_IDLE : BK_DONE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // memory control and handshakes
  always_comb begin
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    we          = 1'b0;
    waddr       = i_q[AW-1:0];
    wdata       = rdata;
    raddr       = i_q[AW-1:0];
    unique case (state_q)
      BK_IDLE: cmd_pop_o = cmd_valid_i;
      BK_SHL_RD: raddr = AW'(i_q + CW'(1));
      BK_SHL_WR: we = 1'b1;
      BK_SHR_RD: begin
        raddr = AW'(i_q - CW'(1));
        if (i_q <= pos_q) begin
          we    = 1'b1;
          waddr = pos_q[AW-1:0];
          wdata = {cur_q.price, cur_q.size};
        end
      end
      BK_SHR_WR: we = 1'b1;
      BK_DECIDE: begin
        if (!remove && same_q) begin
          we    = 1'b1;
          wdata = {cur_q.price, cur_q.size};
        end
      end
      BK_DONE: res_valid_o = res_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      bid_cnt_q <= '0;
      ask_cnt_q <= '0;
      time_q    <= '0;
      status_q  <= ST_APPLIED;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BK_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.op)
              OP_CLEAR: begin
                bid_cnt_q <= '0;
                ask_cnt_q <= '0;
                time_q    <= cmd_i.upd_time;
                status_q  <= ST_APPLIED;
              end
              OP_APPLY: status_q <= ST_APPLIED;
              default:  status_q <= ST_INVALID;
            endcase
          end
        end
        BK_DECIDE: begin
          if (remove || same_q) begin
            time_q <= cur_q.upd_time;
          end else if (n_q >= DEPTH_C && i_q >= DEPTH_C) begin
            status_q <= ST_FULL;
          end
        end
        BK_SHL_RD: begin
          if (!(i_q + CW'(1) < n_q)) begin
            if (cur_q.is_bid) bid_cnt_q <= n_q - CW'(1);
            else              ask_cnt_q <= n_q - CW'(1);
          end
        end
        BK_SHR_RD: begin
          if (i_q <= pos_q) begin
            time_q <= cur_q.upd_time;
            if (cur_q.is_bid) bid_cnt_q <= n_q + CW'(1);
            else              ask_cnt_q <= n_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // search and shift bookkeeping; best level mirrors entry zero
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cur_q  <= cmd_i;
          n_q    <= cmd_i.is_bid ? bid_cnt_q : ask_cnt_q;
          i_q    <= '0;
          same_q <= 1'b0;
        end
      end
      BK_SRCH_CMP: begin
        if (better) i_q <= i_q + CW'(1);
        else        same_q <= (rd_price == cur_q.price);
      end
      BK_DECIDE: begin
        pos_q <= i_q;
        if (!remove && !same_q) begin
          if (n_q >= DEPTH_C) begin
            n_q <= DEPTH_C - CW'(1);
            i_q <= DEPTH_C - CW'(1);
          end else begin
            i_q <= n_q;
          end
        end
      end
      BK_SHL_WR: i_q <= i_q + CW'(1);
      BK_SHR_WR: i_q <= i_q - CW'(1);
      default: ;
    endcase
    if (we && waddr == '0) begin
      if (cur_q.is_bid) best_bid_q <= wdata;
      else              best_ask_q <= wdata;
    end
  end

  always_comb begin
    res_o.status         = status_q;
    res_o.best_bid_price = (bid_cnt_q != '0) ? best_bid_q[ENTRY_W-1:SIZE_W] : '0;
    res_o.best_bid_size  = (bid_cnt_q != '0) ? best_bid_q[SIZE_W-1:0] : '0;
    res_o.best_ask_price = (ask_cnt_q != '0) ? best_ask_q[ENTRY_W-1:SIZE_W] : '0;
    res_o.best_ask_size  = (ask_cnt_q != '0) ? best_ask_q[SIZE_W-1:0] : '0;
    res_o.bid_levels     = 7'(bid_cnt_q);
    res_o.ask_levels     = 7'(ask_cnt_q);
    res_o.book_time      = time_q;
  end

  assign bid_cnt_o = bid_cnt_q;
  assign ask_cnt_o = ask_cnt_q;
endmodule
`default_nettype wire

### rtl/core/price_level_order_book.sv
`default_nettype none
// Two-sided price-level book, BOOK_DEPTH levels per side, bids best-first
// descending and asks best-first ascending, held in one RAM per side.
// A front stage validates each word (price 1..9999, size non-negative) and
// queues it two deep; a back engine applies it and returns one result word
// per input word. Clears and invalid words pass from the idle state
// straight to the done state and leave through the output register. An
// update walks the side from the best level, a read and a compare state
// per level passed (one RAM read port with registered data), then shifts
// the levels behind the change with a read and a write state per level
// moved. The engine sets the rate: it takes a new word only once it is
// through with the last. The best level of each side is mirrored in flops
// so the result word needs no extra read. A full side drops its worst
// level on insert, or rejects a new level that would be worst (status 2).
module price_level_order_book #(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [127:0]  s_axis_tdata_i,  // price[13:0] size[61:14] update_time[125:62]
  input  wire logic [2:0]    s_axis_tuser_i,  // kind[1:0] is_bid[2]
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // best_bid_price[13:0] best_bid_size[60:14] best_ask_price[74:61]
  // best_ask_size[121:75] bid_levels[128:122] ask_levels[135:129] book_time[199:136]
  output logic [199:0]       m_axis_tdata_o,
  output logic [1:0]         m_axis_tuser_o   // status[1:0]
);
  import plob_pkg::*;

  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);

  logic          cmd_valid, cmd_pop, res_valid, out_free;
  cmd_t          cmd;
  res_t          res, out_q;
  logic          out_valid_q;
  logic [CW-1:0] bid_cnt, ask_cnt;

  plob_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_o(s_axis_tready_o),
    .s_user_i(s_axis_tuser_i), .s_data_i(s_axis_tdata_i),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  plob_back #(.BOOK_DEPTH(BOOK_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .res_ready_i(out_free), .res_valid_o(res_valid), .res_o(res),
    .bid_cnt_o(bid_cnt), .ask_cnt_o(ask_cnt)
  );

  // output register: the engine moves on while a word waits here
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.book_time, out_q.ask_levels, out_q.bid_levels,
                            out_q.best_ask_size, out_q.best_ask_price,
                            out_q.best_bid_size, out_q.best_bid_price};

  // level counts never exceed the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_cnt <= CW'(BOOK_DEPTH)) && (ask_cnt <= CW'(BOOK_DEPTH)))
    else $error("level count above depth");

  // a non-empty side always shows a legal best price
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && bid_cnt != '0 |->
      res.best_bid_price != '0 && res.best_bid_price <= PRICE_MAX)
    else $error("bad best bid price");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && ask_cnt != '0 |->
      res.best_ask_price != '0 && res.best_ask_price <= PRICE_MAX)
    else $error("bad best ask price");

  // engine only hands over a result when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result lost");
endmodule
`default_nettype wire
